FILE: sv/humidity_temp_frame_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the humidity / temperature frame decoder
// Immediate-implication and next-cycle checks, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define HTFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htfd assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htfd assertion failed");
`else
`define HTFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 step for the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  localparam int unsigned RAW_W   = 20;
  localparam int unsigned HUM_W   = 14;
  localparam int unsigned TEMP_W  = 15;
  localparam int unsigned FRAC_W  = 20;
  localparam int unsigned HPROD_W = RAW_W + HUM_W;
  localparam int unsigned TPROD_W = RAW_W + TEMP_W;

  localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
  localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
  localparam logic [TEMP_W:0]   TEMP_OFFSET = 16'd5000;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  typedef logic [2:0] byte_pos_t;

  localparam byte_pos_t BYTE_STATUS   = 3'd0;
  localparam byte_pos_t BYTE_HUM_HI   = 3'd1;
  localparam byte_pos_t BYTE_HUM_MID  = 3'd2;
  localparam byte_pos_t BYTE_SPLIT    = 3'd3;
  localparam byte_pos_t BYTE_TEMP_MID = 3'd4;
  localparam byte_pos_t BYTE_TEMP_LO  = 3'd5;
  localparam byte_pos_t BYTE_CRC      = 3'd6;
  localparam byte_pos_t BYTE_UNUSED   = 3'd7;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_hum;
    logic [RAW_W-1:0] raw_tmp;
    logic             crc_ok;
  } frame_rec_t;

  typedef struct packed {
    logic [HUM_W-1:0]         hum;
    logic signed [TEMP_W-1:0] temp;
    logic                     crc_ok;
  } result_rec_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/htfd_fifo.sv
// ----------------------------------------------------------------------------
// htfd_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module htfd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output htfd_pkg::fifo_stat_t stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/htfd_front.sv
// ----------------------------------------------------------------------------
// htfd_front
// Frame assembler: tracks byte position, runs the CRC, gathers raw fields.
// ----------------------------------------------------------------------------
module htfd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_frame_start,
  input  htfd_pkg::fifo_stat_t q_stat,
  output logic                 rec_push,
  output htfd_pkg::frame_rec_t rec
);

  htfd_pkg::byte_pos_t             pos_r, pos_nxt, pos;
  logic [7:0]                      crc_r, crc_nxt;
  logic [htfd_pkg::RAW_W-1:0]      hum_r, hum_nxt;
  logic [htfd_pkg::RAW_W-1:0]      temp_r, temp_nxt;
  logic                            accept;

  assign accept = in_push && !q_stat.full;

  // Start flag or a stray position forces byte 0.
  assign pos = (in_frame_start || pos_r == htfd_pkg::BYTE_UNUSED) ?
               htfd_pkg::BYTE_STATUS : pos_r;

  assign rec.raw_hum  = hum_r;
  assign rec.raw_tmp  = temp_r;
  assign rec.crc_ok   = (in_data_byte == crc_r);
  assign rec_push     = accept && (pos == htfd_pkg::BYTE_CRC);

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    hum_nxt  = hum_r;
    temp_nxt = temp_r;
    if (accept) begin
      if (pos == htfd_pkg::BYTE_CRC) begin
        pos_nxt = htfd_pkg::BYTE_STATUS;
        crc_nxt = htfd_pkg::CRC_INIT;
      end else begin
        pos_nxt = pos + 1'b1;
        crc_nxt = htfd_pkg::crc8_byte(
                    (pos == htfd_pkg::BYTE_STATUS) ? htfd_pkg::CRC_INIT : crc_r,
                    in_data_byte);
      end
      unique case (pos)
        htfd_pkg::BYTE_HUM_HI: begin
          hum_nxt = {in_data_byte, 12'h000};
        end
        htfd_pkg::BYTE_HUM_MID: begin
          hum_nxt = {hum_r[19:12], in_data_byte, 4'h0};
        end
        htfd_pkg::BYTE_SPLIT: begin
          hum_nxt  = {hum_r[19:4], in_data_byte[7:4]};
          temp_nxt = {in_data_byte[3:0], 16'h0000};
        end
        htfd_pkg::BYTE_TEMP_MID: begin
          temp_nxt = {temp_r[19:16], in_data_byte, 8'h00};
        end
        htfd_pkg::BYTE_TEMP_LO: begin
          temp_nxt = {temp_r[19:8], in_data_byte};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= htfd_pkg::BYTE_STATUS;
      crc_r  <= htfd_pkg::CRC_INIT;
      hum_r  <= '0;
      temp_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      hum_r  <= hum_nxt;
      temp_r <= temp_nxt;
    end
  end

endmodule

FILE: sv/htfd_back.sv
// ----------------------------------------------------------------------------
// htfd_back
// Scaler: multiplies raw fields, shifts, offsets, queues finished results.
// ----------------------------------------------------------------------------
module htfd_back #(
  parameter int unsigned OUT_DEPTH = htfd_pkg::OUT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  htfd_pkg::frame_rec_t  rec,
  input  htfd_pkg::fifo_stat_t  q_stat,
  output logic                  rec_pop,
  input  logic                  out_pop,
  output htfd_pkg::result_rec_t res,
  output logic                  out_empty
);

  logic                              s1_valid_r, s1_valid_nxt;
  logic [htfd_pkg::HPROD_W-1:0]      hprod_r;
  logic [htfd_pkg::TPROD_W-1:0]      tprod_r;
  logic                              crc_ok_r;
  logic                              res_push;
  logic [htfd_pkg::TEMP_W:0]         temp_wide;
  htfd_pkg::result_rec_t             res_in;
  htfd_pkg::fifo_stat_t              oq_stat;

  assign res_push = s1_valid_r && !oq_stat.full;
  assign rec_pop  = !q_stat.empty && (!s1_valid_r || !oq_stat.full);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (rec_pop) begin
      s1_valid_nxt = 1'b1;
    end else if (res_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      hprod_r  <= htfd_pkg::HPROD_W'(rec.raw_hum) * htfd_pkg::HPROD_W'(htfd_pkg::HUM_SCALE);
      tprod_r  <= htfd_pkg::TPROD_W'(rec.raw_tmp) * htfd_pkg::TPROD_W'(htfd_pkg::TEMP_SCALE);
      crc_ok_r <= rec.crc_ok;
    end
  end

  // Subtract in one extra bit, then drop it: result range fits signed 15 bits.
  assign temp_wide = {1'b0, tprod_r[htfd_pkg::TPROD_W-1:htfd_pkg::FRAC_W]}
                     - htfd_pkg::TEMP_OFFSET;

  assign res_in.hum    = hprod_r[htfd_pkg::HPROD_W-1:htfd_pkg::FRAC_W];
  assign res_in.temp   = signed'(temp_wide[htfd_pkg::TEMP_W-1:0]);
  assign res_in.crc_ok = crc_ok_r;

  htfd_fifo #(
    .WIDTH ($bits(htfd_pkg::result_rec_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .pop   (out_pop),
    .rdata (res),
    .stat  (oq_stat)
  );

  assign out_empty = oq_stat.empty;

endmodule

FILE: sv/humidity_temp_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core: 7-byte sensor reply decoder with CRC-8
// Takes one byte per cycle while in_full is low; one result per seven bytes, set by the front.
// A result passes the middle queue, the multiply stage and the output queue to out_ ports.
// Reset (sync, active low) empties both queues and restarts the frame at byte 0.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_core_assert.svh"

module humidity_temp_frame_decoder_core #(
  parameter int unsigned MID_DEPTH = htfd_pkg::MID_DEPTH,
  parameter int unsigned OUT_DEPTH = htfd_pkg::OUT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // byte channel
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_frame_start,
  // result channel
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [htfd_pkg::HUM_W-1:0]        out_humidity_centi,
  output logic signed [htfd_pkg::TEMP_W-1:0] out_temperature_centi,
  output logic                              out_crc_ok
);

  // Front: every accepted byte beat updates the registered position, CRC and raw fields.
  // On the CRC byte it emits a frame record (raw fields plus CRC verdict).
  // Middle queue: decouples the front from the scaler so either may stall.
  // Back: one multiply stage, then shift/offset into the output queue.

  htfd_pkg::frame_rec_t  rec_in, rec_out;
  htfd_pkg::fifo_stat_t  mid_stat;
  htfd_pkg::result_rec_t res;
  logic                  mid_push, mid_pop;

  // Hold off bytes only while the frame record queue is full.
  assign in_full = mid_stat.full;

  htfd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .q_stat         (mid_stat),
    .rec_push       (mid_push),
    .rec            (rec_in)
  );

  htfd_fifo #(
    .WIDTH ($bits(htfd_pkg::frame_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (rec_in),
    .pop   (mid_pop),
    .rdata (rec_out),
    .stat  (mid_stat)
  );

  htfd_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (rec_out),
    .q_stat    (mid_stat),
    .rec_pop   (mid_pop),
    .out_pop   (out_pop),
    .res       (res),
    .out_empty (out_empty)
  );

  // Drive result ports from the head of the output queue.
  assign out_humidity_centi    = res.hum;
  assign out_temperature_centi = res.temp;
  assign out_crc_ok            = res.crc_ok;

  // A CRC byte beat must leave a frame record waiting in the middle queue.
  `HTFD_ASSERT_NEXT(a_frame_queued, clk, rst_n, mid_push, !mid_stat.empty)
  // Scaled humidity never exceeds 99.99 percent.
  `HTFD_ASSERT_IMPLIES(a_hum_range, clk, rst_n, !out_empty, out_humidity_centi <= 14'd9999)
  // Offset temperature never drops below -50.00 degrees.
  `HTFD_ASSERT_IMPLIES(a_temp_range, clk, rst_n, !out_empty, out_temperature_centi >= -15'sd5000)

endmodule

FILE: tb/htfd_reading_checker.sv
// ----------------------------------------------------------------------------
// htfd_reading_checker
// Watches the byte and result channels of the frame decoder, decodes every
// accepted byte on its own and compares each popped reading field by field.
// ----------------------------------------------------------------------------
module htfd_reading_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  logic                               in_full,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_frame_start,
  input  logic                               out_empty,
  input  logic                               out_pop,
  input  logic [htfd_pkg::HUM_W-1:0]         out_humidity_centi,
  input  logic signed [htfd_pkg::TEMP_W-1:0] out_temperature_centi,
  input  logic                               out_crc_ok,
  output int                                 mismatch_count,
  output int                                 readings_pending,
  output int                                 readings_checked,
  output int                                 bad_crc_readings
);
  import htfd_pkg::*;

  typedef struct {
    logic [HUM_W-1:0]         hum;
    logic signed [TEMP_W-1:0] temp;
    logic                     crc_ok;
  } reading_t;

  byte_pos_t        frame_pos;
  logic [7:0]       frame_crc;
  logic [RAW_W-1:0] hum_raw;
  logic [RAW_W-1:0] temp_raw;
  reading_t         expected_readings[$];

  // Shift the byte in one bit at a time, MSB first.
  function automatic logic [7:0] crc_shift_in(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic reading_t scale_reading(input logic [RAW_W-1:0] h,
                                             input logic [RAW_W-1:0] t,
                                             input logic ok);
    logic [HPROD_W-1:0] hp;
    logic [TPROD_W-1:0] tp;
    int                 tc;
    reading_t           r;
    hp = HPROD_W'(h) * HPROD_W'(HUM_SCALE);
    tp = TPROD_W'(t) * TPROD_W'(TEMP_SCALE);
    tc = int'(tp[TPROD_W-1:FRAC_W]) - int'(TEMP_OFFSET);
    r.hum    = hp[HPROD_W-1:FRAC_W];
    r.temp   = tc[TEMP_W-1:0];
    r.crc_ok = ok;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic start);
    byte_pos_t pos;
    pos = start ? BYTE_STATUS : frame_pos;
    if (pos == BYTE_UNUSED) begin
      pos = BYTE_STATUS;
    end
    if (pos == BYTE_CRC) begin
      expected_readings.push_back(scale_reading(hum_raw, temp_raw, b == frame_crc));
      frame_pos = BYTE_STATUS;
      frame_crc = CRC_INIT;
    end else begin
      frame_crc = crc_shift_in((pos == BYTE_STATUS) ? CRC_INIT : frame_crc, b);
      case (pos)
        BYTE_HUM_HI:   hum_raw  = {b, 12'h000};
        BYTE_HUM_MID:  hum_raw  = {hum_raw[19:12], b, 4'h0};
        BYTE_SPLIT: begin
          hum_raw[3:0] = b[7:4];
          temp_raw     = {b[3:0], 16'h0000};
        end
        BYTE_TEMP_MID: temp_raw = {temp_raw[19:16], b, 8'h00};
        BYTE_TEMP_LO:  temp_raw = {temp_raw[19:8], b};
        default: ;
      endcase
      frame_pos = pos + 3'd1;
    end
  endtask

  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst_n) begin
      frame_pos        = BYTE_STATUS;
      frame_crc        = CRC_INIT;
      hum_raw          = '0;
      temp_raw         = '0;
      mismatch_count   = 0;
      readings_checked = 0;
      bad_crc_readings = 0;
      expected_readings.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_readings.size() == 0) begin
          $error("result beat with no reading expected");
          mismatch_count++;
        end else begin
          exp_r = expected_readings.pop_front();
          if (out_humidity_centi !== exp_r.hum) begin
            $error("humidity_centi: expected %0d, got %0d", exp_r.hum, out_humidity_centi);
            mismatch_count++;
          end
          if (out_temperature_centi !== exp_r.temp) begin
            $error("temperature_centi: expected %0d, got %0d",
                   exp_r.temp, out_temperature_centi);
            mismatch_count++;
          end
          if (out_crc_ok !== exp_r.crc_ok) begin
            $error("crc_ok: expected %0d, got %0d", exp_r.crc_ok, out_crc_ok);
            mismatch_count++;
          end
          readings_checked++;
          if (!exp_r.crc_ok) begin
            bad_crc_readings++;
          end
        end
      end
      if (in_push && !in_full) begin
        decode_byte(in_data_byte, in_frame_start);
      end
    end
    readings_pending = expected_readings.size();
  end

endmodule

FILE: tb/humidity_temp_frame_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core_tb
// Feeds sensor reply frames byte by byte into the decoder: a few hand-built
// frames first, then about a thousand bytes of random frames, corrupted
// frames, cut-off frames and loose bytes. A checker beside the block decodes
// the same bytes and compares every reading that gets popped.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_core_tb;
  import htfd_pkg::*;

  localparam int ITEMS           = 1000;
  localparam int HOLD_OFF_CYCLES = 400;  // one long receiver stall
  localparam int HOLD_OFF_AT_POP = 30;
  localparam int DRAIN_CYCLES    = 10;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic [7:0]               in_data_byte;
  logic                     in_frame_start;
  logic                     out_empty;
  logic                     out_pop;
  logic [HUM_W-1:0]         out_humidity_centi;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic                     out_crc_ok;

  int mismatch_count;
  int readings_pending;
  int readings_checked;
  int bad_crc_readings;

  // Stimulus bookkeeping
  bit rush;               // both sides go back to back while set
  bit aligned;            // the block sits at byte 0 of a frame
  int bytes_sent  = 0;
  int frames_sent = 0;
  int full_stalls = 0;

  humidity_temp_frame_decoder_core u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_data_byte          (in_data_byte),
    .in_frame_start        (in_frame_start),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_humidity_centi    (out_humidity_centi),
    .out_temperature_centi (out_temperature_centi),
    .out_crc_ok            (out_crc_ok)
  );

  htfd_reading_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_data_byte          (in_data_byte),
    .in_frame_start        (in_frame_start),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_humidity_centi    (out_humidity_centi),
    .out_temperature_centi (out_temperature_centi),
    .out_crc_ok            (out_crc_ok),
    .mismatch_count        (mismatch_count),
    .readings_pending      (readings_pending),
    .readings_checked      (readings_checked),
    .bad_crc_readings      (bad_crc_readings)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles where the sender offers a byte and the block pushes back.
  always @(posedge clk) begin
    if (rst_n && in_push && in_full) begin
      full_stalls++;
    end
  end

  // Push one byte beat. Enter and leave at a falling edge; hold push high
  // across back-to-back beats instead of dropping and raising it.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data_byte   = b;
    in_frame_start = start;
    in_push        = 1'b1;
    do @(posedge clk); while (in_full);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Build a reply frame and push its first `keep` bytes. Spoil the CRC byte
  // on request by flipping one random bit.
  task automatic send_frame(input logic [7:0] status, input logic [RAW_W-1:0] hum,
                            input logic [RAW_W-1:0] tmp, input bit use_start,
                            input bit spoil_crc, input int keep);
    logic [7:0] frame_bytes [7];
    logic [7:0] crc;
    frame_bytes[0] = status;
    frame_bytes[1] = hum[19:12];
    frame_bytes[2] = hum[11:4];
    frame_bytes[3] = {hum[3:0], tmp[19:16]};
    frame_bytes[4] = tmp[15:8];
    frame_bytes[5] = tmp[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc8_byte(crc, frame_bytes[i]);
    end
    if (spoil_crc) begin
      crc = crc ^ (8'h01 << $urandom_range(0, 7));
    end
    frame_bytes[6] = crc;
    for (int i = 0; i < keep; i++) begin
      send_byte(frame_bytes[i], (i == 0) && use_start);
    end
    if (keep == 7) begin
      frames_sent++;
    end
    aligned = (keep == 7);
  endtask

  // Mostly random raw values, with the ends of the range mixed in.
  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return RAW_W'($urandom_range(0, 20'hFFFFF));
    endcase
  endfunction

  // Result side: draw a pop delay per reading, stall once for a long
  // stretch so the block fills up and pushes back on the byte channel.
  initial begin : result_drain
    int gap;
    int pops;
    out_pop = 1'b0;
    pops    = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = rush ? 0 : $urandom_range(0, 9);
      if (pops == HOLD_OFF_AT_POP) begin
        gap = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        out_pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop = 1'b1;
      do @(posedge clk); while (out_empty);
      pops++;
      @(negedge clk);
    end
  end

  // Main stimulus and verdict.
  initial begin : byte_source
    int kind;
    int n;
    in_push        = 1'b0;
    in_data_byte   = 8'h00;
    in_frame_start = 1'b0;
    rst_n          = 1'b0;
    rush           = 1'b0;
    aligned        = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: all-zero raw values with the start flag (lowest humidity
    // and temperature), then all-ones raw values without the start flag
    // right after a finished frame (highest readings).
    send_frame(8'h00, 20'h00000, 20'h00000, 1'b1, 1'b0, 7);
    send_frame(8'hFF, 20'hFFFFF, 20'hFFFFF, 1'b0, 1'b0, 7);
    // Cut a frame off just before its CRC byte, start a new frame with the start
    // flag on what would have been the CRC position, and spoil its CRC.
    send_frame(8'h1C, 20'h8A5C3, 20'h5F0E1, 1'b1, 1'b0, 6);
    send_frame(8'h5A, 20'h7FFFF, 20'h80000, 1'b1, 1'b1, 7);

    // Random: mostly well-formed frames with random content, the rest bad
    // CRCs, cut-off frames and loose bytes. Frames after a broken sequence
    // always carry the start flag; after a clean one, only sometimes.
    while (bytes_sent < ITEMS) begin
      if ($urandom_range(0, 15) == 0) begin
        rush = !rush;
      end
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        send_frame(8'($urandom), pick_raw(), pick_raw(),
                   aligned ? 1'($urandom_range(0, 1)) : 1'b1, 1'b0, 7);
      end else if (kind < 16) begin
        send_frame(8'($urandom), pick_raw(), pick_raw(), 1'b1, 1'b1, 7);
      end else if (kind < 18) begin
        send_frame(8'($urandom), pick_raw(), pick_raw(), 1'b1, 1'b0,
                   $urandom_range(1, 6));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        end
        aligned = 1'b0;
      end
    end
    in_push = 1'b0;
    rush    = 1'b0;

    // Drain: wait for every expected reading, then let the pipe settle.
    while (readings_pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d bytes, %0d complete frames, %0d readings checked (%0d bad CRC).",
             bytes_sent, frames_sent, readings_checked, bad_crc_readings);
    $display("Byte channel held off by a full block for %0d cycles.", full_stalls);
    if (mismatch_count == 0 && readings_pending == 0) begin
      $display("PASS humidity_temp_frame_decoder_core");
    end else begin
      $display("FAIL humidity_temp_frame_decoder_core");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL humidity_temp_frame_decoder_core");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/htfd_pkg.sv
sv/htfd_fifo.sv
sv/htfd_front.sv
sv/htfd_back.sv
sv/humidity_temp_frame_decoder_core.sv
tb/htfd_reading_checker.sv
tb/humidity_temp_frame_decoder_core_tb.sv
